/* hdl/vgbs_pkg.sv */
// Package for the vector grid bilinear sampler.
// Holds grid sizes, register indexes, shared types and the count helper.
// No dependencies.
package vgbs_pkg;

   localparam int MaxCols = 64;
   localparam int MaxRows = 64;
   localparam int Cells   = MaxCols * MaxRows;
   localparam int AddrW   = $clog2(Cells);
   localparam int ColW    = $clog2(MaxCols);
   localparam int RowW    = $clog2(MaxRows);
   localparam int CntW    = 7;
   localparam int QDepth  = 4;
   localparam int QPtrW   = $clog2(QDepth);

   localparam logic FuncWrite  = 1'b0;
   localparam logic FuncSample = 1'b1;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type RegGridValid = 3'd0;
   localparam csr_index_type RegOriginX   = 3'd1;
   localparam csr_index_type RegOriginY   = 3'd2;
   localparam csr_index_type RegInvCellX  = 3'd3;
   localparam csr_index_type RegInvCellY  = 3'd4;
   localparam csr_index_type RegCols      = 3'd5;
   localparam csr_index_type RegRows      = 3'd6;

   typedef struct packed {
      logic                grid_valid;
      logic signed [31:0]  origin_x;
      logic signed [31:0]  origin_y;
      logic [31:0]         inv_cell_x;
      logic [31:0]         inv_cell_y;
      logic [CntW-1:0]     nx;
      logic [CntW-1:0]     ny;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic               in_grid;
      logic [AddrW-1:0]   a00;
      logic [AddrW-1:0]   a10;
      logic [AddrW-1:0]   a01;
      logic [AddrW-1:0]   a11;
      logic signed [31:0] wvx;
      logic signed [31:0] wvy;
      logic [15:0]        tx;
      logic [15:0]        ty;
   } job_type;

   function automatic logic [CntW-1:0] eff_count(input logic [CntW-1:0] n,
                                                 input logic [CntW-1:0] maxn);
      logic [CntW-1:0] r;
      r = n;
      if (n == '0) r = CntW'(1);
      else if (n > maxn) r = maxn;
      return r;
   endfunction

endpackage

/* hdl/vgbs_front.sv */
// Front part: accepts items, maps sample points to grid indices and addresses.
// Depends on vgbs_pkg; feeds vgbs_queue.
module vgbs_front import vgbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_func,
   input  logic [11:0]        req_cell_index,
   input  logic signed [31:0] req_write_vx,
   input  logic signed [31:0] req_write_vy,
   input  logic signed [31:0] req_sample_x,
   input  logic signed [31:0] req_sample_y,
   input  logic [QPtrW:0]     q_count,
   output logic               q_push,
   output job_type            q_job
);

   logic               v1_ff, v1_in, v2_ff, v2_in, acc;
   logic               f1_ff, f2_ff;
   logic [11:0]        ci1_ff, ci2_ff;
   logic signed [31:0] wx1_ff, wy1_ff, wx2_ff, wy2_ff;
   logic signed [32:0] dx_ff, dy_ff, dx_in, dy_in;
   logic               nx2_ff, ny2_ff;
   logic [47:0]        qx_ff, qy_ff, qx_in, qy_in;
   logic [63:0]        px, py;
   logic [CntW-1:0]    nxm1, nym1;
   logic               inx, iny;
   logic [ColW-1:0]    ix0, ix1;
   logic [RowW-1:0]    iy0, iy1;
   logic [RowW+CntW-1:0] r0, r1;

   assign req_full = (3'(q_count) + 3'(v1_ff) + 3'(v2_ff)) >= 3'(QDepth);
   assign acc      = req_push && !req_full;
   assign v1_in    = acc;
   assign v2_in    = v1_ff;

   assign dx_in = {req_sample_x[31], req_sample_x} - {cfg.origin_x[31], cfg.origin_x};
   assign dy_in = {req_sample_y[31], req_sample_y} - {cfg.origin_y[31], cfg.origin_y};
   assign px    = dx_ff[31:0] * cfg.inv_cell_x;
   assign py    = dy_ff[31:0] * cfg.inv_cell_y;
   assign qx_in = px[63:16];
   assign qy_in = py[63:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      f1_ff  <= req_func;
      ci1_ff <= req_cell_index;
      wx1_ff <= req_write_vx;
      wy1_ff <= req_write_vy;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      f2_ff  <= f1_ff;
      ci2_ff <= ci1_ff;
      wx2_ff <= wx1_ff;
      wy2_ff <= wy1_ff;
      nx2_ff <= dx_ff[32];
      ny2_ff <= dy_ff[32];
      qx_ff  <= qx_in;
      qy_ff  <= qy_in;
   end

   always_comb begin
      nxm1 = cfg.nx - CntW'(1);
      nym1 = cfg.ny - CntW'(1);
      inx  = !nx2_ff && (qx_ff <= {(48 - CntW - 16)'(0), nxm1, 16'd0});
      iny  = !ny2_ff && (qy_ff <= {(48 - CntW - 16)'(0), nym1, 16'd0});
      ix0  = qx_ff[16 +: ColW];
      iy0  = qy_ff[16 +: RowW];
      ix1  = ((CntW'(ix0) + CntW'(1)) < cfg.nx) ? ColW'(CntW'(ix0) + CntW'(1))
                                                : ColW'(nxm1);
      iy1  = ((CntW'(iy0) + CntW'(1)) < cfg.ny) ? RowW'(CntW'(iy0) + CntW'(1))
                                                : RowW'(nym1);
      r0   = iy0 * cfg.nx;
      r1   = iy1 * cfg.nx;
      q_job.func    = f2_ff;
      q_job.in_grid = cfg.grid_valid && inx && iny;
      q_job.wvx     = wx2_ff;
      q_job.wvy     = wy2_ff;
      q_job.tx      = qx_ff[15:0];
      q_job.ty      = qy_ff[15:0];
      if (f2_ff == FuncWrite) begin
         q_job.a00 = AddrW'(ci2_ff);
         q_job.a10 = AddrW'(ci2_ff);
         q_job.a01 = AddrW'(ci2_ff);
         q_job.a11 = AddrW'(ci2_ff);
      end else begin
         q_job.a00 = AddrW'(r0 + (RowW+CntW)'(ix0));
         q_job.a10 = AddrW'(r0 + (RowW+CntW)'(ix1));
         q_job.a01 = AddrW'(r1 + (RowW+CntW)'(ix0));
         q_job.a11 = AddrW'(r1 + (RowW+CntW)'(ix1));
      end
   end

   assign q_push = v2_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < (QPtrW+1)'(QDepth)))
      else $error("front pushed into a full queue");
   a_pipe: assert property (@(posedge clock) disable iff (reset)
      acc |=> ##1 q_push)
      else $error("accepted transaction lost in front pipe");
   a_full_credit: assert property (@(posedge clock) disable iff (reset)
      (q_count == (QPtrW+1)'(QDepth)) |-> req_full)
      else $error("full not raised with queue full");

endmodule

/* hdl/vgbs_queue.sv */
// Short queue of decoded jobs between front and back parts.
// Depends on vgbs_pkg.
module vgbs_queue import vgbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  job_type        din,
   input  logic           pop,
   output job_type        dout,
   output logic           empty,
   output logic [QPtrW:0] count
);

   job_type            mem_ff [QDepth];
   logic [QPtrW-1:0]   wp_ff, rp_ff;
   logic [QPtrW:0]     cnt_ff, cnt_in;

   assign cnt_in = cnt_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
   assign count  = cnt_ff;
   assign empty  = (cnt_ff == '0);
   assign dout   = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= wp_ff + QPtrW'(1);
         if (pop)  rp_ff <= rp_ff + QPtrW'(1);
      end
      if (push) mem_ff[wp_ff] <= din;
   end

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");
   a_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + (QPtrW+1)'(1)))
      else $error("queue count did not advance");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPtrW+1)'(QDepth))
      else $error("queue count beyond depth");

endmodule

/* hdl/vgbs_back.sv */
// Back part: grid store in four copies, bilinear blend pipeline, result queue.
// Depends on vgbs_pkg; takes jobs from vgbs_queue.
module vgbs_back import vgbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  job_type            job,
   input  logic               job_empty,
   output logic               job_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_current_x,
   output logic signed [31:0] rsp_current_y,
   output logic               rsp_inside_res
);

   localparam int ODepth = 8;
   localparam int OPtrW  = $clog2(ODepth);

   logic [63:0] m00 [Cells];
   logic [63:0] m10 [Cells];
   logic [63:0] m01 [Cells];
   logic [63:0] m11 [Cells];

   logic               smp, credit;
   logic               b1_ff, b2_ff, b3_ff;
   logic               in1_ff, in2_ff, in3_ff;
   logic [15:0]        tx1_ff, ty1_ff, ty2_ff;
   logic [63:0]        d00_ff, d10_ff, d01_ff, d11_ff;
   logic signed [17:0] wx0, wx1, wy0, wy1;
   logic signed [49:0] a0x_in, a1x_in, a0y_in, a1y_in;
   logic signed [49:0] a0x_ff, a1x_ff, a0y_ff, a1y_ff;
   logic signed [67:0] sx_in, sy_in, sx_ff, sy_ff;
   logic [64:0]        ores_mem [ODepth];
   logic [OPtrW-1:0]   owp_ff, orp_ff;
   logic [OPtrW:0]     ocnt_ff, ocnt_in;
   logic               opush, opop;
   logic [64:0]        ores_in;

   assign smp     = (job.func == FuncSample);
   assign credit  = ((OPtrW+2)'(ocnt_ff) + (OPtrW+2)'(b1_ff) + (OPtrW+2)'(b2_ff)
                     + (OPtrW+2)'(b3_ff)) < (OPtrW+2)'(ODepth);
   assign job_pop = !job_empty && (!smp || credit);

   always_ff @(posedge clock) begin
      if (job_pop) begin
         if (!smp) begin
            m00[job.a00] <= {job.wvx, job.wvy};
            m10[job.a00] <= {job.wvx, job.wvy};
            m01[job.a00] <= {job.wvx, job.wvy};
            m11[job.a00] <= {job.wvx, job.wvy};
         end else begin
            d00_ff <= m00[job.a00];
            d10_ff <= m10[job.a10];
            d01_ff <= m01[job.a01];
            d11_ff <= m11[job.a11];
         end
      end
   end

   always_comb begin
      wx1    = $signed({2'b00, tx1_ff});
      wx0    = 18'sh10000 - wx1;
      wy1    = $signed({2'b00, ty2_ff});
      wy0    = 18'sh10000 - wy1;
      a0x_in = wx0 * $signed(d00_ff[63:32]) + wx1 * $signed(d10_ff[63:32]);
      a1x_in = wx0 * $signed(d01_ff[63:32]) + wx1 * $signed(d11_ff[63:32]);
      a0y_in = wx0 * $signed(d00_ff[31:0])  + wx1 * $signed(d10_ff[31:0]);
      a1y_in = wx0 * $signed(d01_ff[31:0])  + wx1 * $signed(d11_ff[31:0]);
      sx_in  = wy0 * a0x_ff + wy1 * a1x_ff;
      sy_in  = wy0 * a0y_ff + wy1 * a1y_ff;
      ores_in = in3_ff ? {sx_ff[63:32], sy_ff[63:32], 1'b1} : 65'd0;
   end

   assign opush   = b3_ff;
   assign opop    = rsp_pop && !rsp_empty;
   assign ocnt_in = ocnt_ff + (OPtrW+1)'(opush) - (OPtrW+1)'(opop);

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_ff   <= 1'b0;
         b2_ff   <= 1'b0;
         b3_ff   <= 1'b0;
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         b1_ff   <= job_pop && smp;
         b2_ff   <= b1_ff;
         b3_ff   <= b2_ff;
         ocnt_ff <= ocnt_in;
         if (opush) owp_ff <= owp_ff + OPtrW'(1);
         if (opop)  orp_ff <= orp_ff + OPtrW'(1);
      end
      in1_ff <= job.in_grid;
      tx1_ff <= job.tx;
      ty1_ff <= job.ty;
      in2_ff <= in1_ff;
      ty2_ff <= ty1_ff;
      a0x_ff <= a0x_in;
      a1x_ff <= a1x_in;
      a0y_ff <= a0y_in;
      a1y_ff <= a1y_in;
      in3_ff <= in2_ff;
      sx_ff  <= sx_in;
      sy_ff  <= sy_in;
      if (opush) ores_mem[owp_ff] <= ores_in;
   end

   assign rsp_empty      = (ocnt_ff == '0);
   assign rsp_current_x  = $signed(ores_mem[orp_ff][64:33]);
   assign rsp_current_y  = $signed(ores_mem[orp_ff][32:1]);
   assign rsp_inside_res = ores_mem[orp_ff][0];

   a_oflow: assert property (@(posedge clock) disable iff (reset)
      opush |-> (ocnt_ff < (OPtrW+1)'(ODepth) || opop))
      else $error("result queue overflow");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (job_pop && smp) |=> ##2 opush)
      else $error("sample transaction lost in blend pipe");
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_inside_res) |-> (rsp_current_x == 0 && rsp_current_y == 0))
      else $error("outside result not zero");

endmodule

/* hdl/vector_grid_bilinear_sampler_top.sv */
// Top level of the vector grid bilinear sampler: registers, front, queue, back.
// Depends on vgbs_pkg, vgbs_front, vgbs_queue and vgbs_back.
// Accepts one transaction per cycle, write or sample, while the result queue has room.
// A sample result reaches the result ports through offset, 32x32 reciprocal multiply,
// index and address into the job queue, a registered read of the four grid copies,
// two blend multiply stages and the result queue write. Input stalls only when
// results are not popped and the result queue fills. Writes give no result and take
// effect in order with samples. Reading a cell never written yields an undefined value.
module vector_grid_bilinear_sampler_top import vgbs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_func,
   input  logic [11:0]        req_cell_index,
   input  logic signed [31:0] req_write_vx,
   input  logic signed [31:0] req_write_vy,
   input  logic signed [31:0] req_sample_x,
   input  logic signed [31:0] req_sample_y,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_current_x,
   output logic signed [31:0] rsp_current_y,
   output logic               rsp_inside_res,
   input  logic               csr_we,
   input  csr_index_type      csr_index,
   input  logic [31:0]        csr_wdata
);

   logic               gv_ff;
   logic signed [31:0] ox_ff, oy_ff;
   logic [31:0]        icx_ff, icy_ff;
   logic [CntW-1:0]    cols_ff, rows_ff;
   cfg_type            cfg;
   logic               q_push, q_pop, q_empty;
   job_type            q_din, q_dout;
   logic [QPtrW:0]     q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         gv_ff   <= 1'b0;
         ox_ff   <= '0;
         oy_ff   <= '0;
         icx_ff  <= 32'd65536;
         icy_ff  <= 32'd65536;
         cols_ff <= CntW'(64);
         rows_ff <= CntW'(64);
      end else if (csr_we) begin
         unique case (csr_index)
            RegGridValid: gv_ff   <= csr_wdata[0];
            RegOriginX:   ox_ff   <= $signed(csr_wdata);
            RegOriginY:   oy_ff   <= $signed(csr_wdata);
            RegInvCellX:  icx_ff  <= csr_wdata;
            RegInvCellY:  icy_ff  <= csr_wdata;
            RegCols:      cols_ff <= csr_wdata[CntW-1:0];
            RegRows:      rows_ff <= csr_wdata[CntW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.grid_valid = gv_ff;
      cfg.origin_x   = ox_ff;
      cfg.origin_y   = oy_ff;
      cfg.inv_cell_x = icx_ff;
      cfg.inv_cell_y = icy_ff;
      cfg.nx         = eff_count(cols_ff, CntW'(MaxCols));
      cfg.ny         = eff_count(rows_ff, CntW'(MaxRows));
   end

   vgbs_front u_front (
      .clock, .reset, .cfg,
      .req_push, .req_full, .req_func, .req_cell_index,
      .req_write_vx, .req_write_vy, .req_sample_x, .req_sample_y,
      .q_count, .q_push, .q_job(q_din)
   );

   vgbs_queue u_queue (
      .clock, .reset, .push(q_push), .din(q_din), .pop(q_pop),
      .dout(q_dout), .empty(q_empty), .count(q_count)
   );

   vgbs_back u_back (
      .clock, .reset, .job(q_dout), .job_empty(q_empty), .job_pop(q_pop),
      .rsp_empty, .rsp_pop, .rsp_current_x, .rsp_current_y, .rsp_inside_res
   );

endmodule
